// ===== hdl/lrast_pkg.sv =====
// Operation codes and fixed constants for the line rasteriser.
package lrast_pkg;

	// Operation carried in the input tuser bit.
	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_ADVANCE = 1'b1;

	// Number of endpoint coordinates packed into the input tdata.
	localparam int unsigned IN_COORDS  = 4;
	// Number of point coordinates packed into the output tdata.
	localparam int unsigned OUT_COORDS = 2;

endpackage

// ===== hdl/lrast_setup.sv =====
// Line set-up: major axis choice, endpoint ordering and initial Bresenham terms.
module lrast_setup #(
	parameter int COORD_BITS = 12
) (
	input  logic signed [COORD_BITS-1:0] ax,
	input  logic signed [COORD_BITS-1:0] ay,
	input  logic signed [COORD_BITS-1:0] bx,
	input  logic signed [COORD_BITS-1:0] by,
	output logic                         steep,
	output logic                         reversed,
	output logic                         minor_step_neg,
	output logic signed [COORD_BITS-1:0] major_pos,
	output logic signed [COORD_BITS-1:0] minor_pos,
	output logic        [COORD_BITS-1:0] major_delta,
	output logic        [COORD_BITS-1:0] minor_delta,
	output logic signed [COORD_BITS+1:0] decision
);

	localparam int N = COORD_BITS;

	logic signed [N:0]   dx;
	logic signed [N:0]   dy;
	logic signed [N:0]   adx;
	logic signed [N:0]   ady;
	logic signed [N-1:0] amaj;
	logic signed [N-1:0] amin;
	logic signed [N-1:0] bmaj;
	logic signed [N-1:0] bmin;
	logic signed [N-1:0] lo_maj;
	logic signed [N-1:0] lo_min;
	logic signed [N-1:0] hi_maj;
	logic signed [N-1:0] hi_min;
	logic signed [N:0]   dmin;
	logic signed [N:0]   admin;
	logic        [N:0]   dmaj;

	// Extents along both axes; y is the major axis on a tie.
	always_comb begin
		dx  = {bx[N-1], bx} - {ax[N-1], ax};
		dy  = {by[N-1], by} - {ay[N-1], ay};
		adx = dx[N] ? -dx : dx;
		ady = dy[N] ? -dy : dy;
		steep = !(ady < adx);
	end

	// Map onto major and minor axes, then order so that the major coordinate rises.
	always_comb begin
		if (steep) begin
			amaj = ay;
			amin = ax;
			bmaj = by;
			bmin = bx;
		end else begin
			amaj = ax;
			amin = ay;
			bmaj = bx;
			bmin = by;
		end
		reversed = amaj > bmaj;
		if (reversed) begin
			lo_maj = bmaj;
			lo_min = bmin;
			hi_maj = amaj;
			hi_min = amin;
		end else begin
			lo_maj = amaj;
			lo_min = amin;
			hi_maj = bmaj;
			hi_min = bmin;
		end
	end

	// Initial Bresenham terms for the ordered line.
	always_comb begin
		dmin           = {hi_min[N-1], hi_min} - {lo_min[N-1], lo_min};
		admin          = dmin[N] ? -dmin : dmin;
		minor_step_neg = dmin[N];
		minor_delta    = admin[N-1:0];
		dmaj           = {hi_maj[N-1], hi_maj} - {lo_maj[N-1], lo_maj};
		major_delta    = dmaj[N-1:0];
		major_pos      = lo_maj;
		minor_pos      = lo_min;
		decision       = $signed({1'b0, minor_delta, 1'b0}) - $signed({2'b00, major_delta});
	end

endmodule

// ===== hdl/line_rasterizer_top.sv =====
// Top level of the Bresenham line rasteriser with stream input and output.
// Throughput: one transaction per cycle on the input, loads and advances alike, while the output is not stalled.
// An accepted advance passes from the input register into the result register, which
// offers its point on the output.
// A load gives no point; a stalled output holds the input register until the point is taken.
// Reset (arst_n low) clears all line state, so advances before the first load give no point.
module line_rasterizer_top #(
	parameter int COORD_BITS = 12
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// Fields from bit 0 up: start_x, start_y, end_x, end_y, zero fill to whole bytes.
	input  logic [((lrast_pkg::IN_COORDS*COORD_BITS+7)/8)*8-1:0] s_tdata,
	// Fields from bit 0 up: operation.
	input  logic s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// Fields from bit 0 up: point_x, point_y, zero fill to whole bytes.
	output logic [((lrast_pkg::OUT_COORDS*COORD_BITS+7)/8)*8-1:0] m_tdata,
	// Marks the final point of the line.
	output logic m_tlast,
	// Fields from bit 0 up: backward.
	output logic m_tuser
);

	localparam int N          = COORD_BITS;
	localparam int OUT_DATA_W = ((lrast_pkg::OUT_COORDS*COORD_BITS+7)/8)*8;

	// Input register.
	logic                in_valid_s1;
	logic                op_s1;
	logic signed [N-1:0] ax_s1;
	logic signed [N-1:0] ay_s1;
	logic signed [N-1:0] bx_s1;
	logic signed [N-1:0] by_s1;

	// Line state.
	logic signed [N-1:0] major_pos_q;
	logic signed [N-1:0] minor_pos_q;
	logic signed [N+1:0] decision_q;
	logic        [N-1:0] major_delta_q;
	logic        [N-1:0] minor_delta_q;
	logic        [N-1:0] remaining_q;
	logic                minor_step_neg_q;
	logic                steep_q;
	logic                reversed_q;

	// Result register.
	logic                out_valid_q;
	logic signed [N-1:0] out_x_q;
	logic signed [N-1:0] out_y_q;
	logic                out_last_q;
	logic                out_back_q;

	// Set-up results for a load.
	logic                su_steep;
	logic                su_reversed;
	logic                su_minor_step_neg;
	logic signed [N-1:0] su_major_pos;
	logic signed [N-1:0] su_minor_pos;
	logic        [N-1:0] su_major_delta;
	logic        [N-1:0] su_minor_delta;
	logic signed [N+1:0] su_decision;

	logic                s1_go;
	logic                s1_fire;
	logic                is_load;
	logic                emit;
	logic signed [N+2:0] dec_next;
	logic signed [N-1:0] minor_next;

	// Handshake: the input register moves on whenever the result register can take a value.
	assign s1_go    = !out_valid_q || m_tready;
	assign s_tready = !in_valid_s1 || s1_go;
	assign s1_fire  = in_valid_s1 && s1_go;
	assign is_load  = (op_s1 == lrast_pkg::OP_LOAD);
	assign emit     = s1_fire && (op_s1 == lrast_pkg::OP_ADVANCE) && (remaining_q != '0);

	// Input register; payload needs no reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1 <= s_tuser;
			ax_s1 <= s_tdata[N-1:0];
			ay_s1 <= s_tdata[2*N-1:N];
			bx_s1 <= s_tdata[3*N-1:2*N];
			by_s1 <= s_tdata[4*N-1:3*N];
		end
	end

	lrast_setup #(
		.COORD_BITS(COORD_BITS)
	) u_setup (
		.ax            (ax_s1),
		.ay            (ay_s1),
		.bx            (bx_s1),
		.by            (by_s1),
		.steep         (su_steep),
		.reversed      (su_reversed),
		.minor_step_neg(su_minor_step_neg),
		.major_pos     (su_major_pos),
		.minor_pos     (su_minor_pos),
		.major_delta   (su_major_delta),
		.minor_delta   (su_minor_delta),
		.decision      (su_decision)
	);

	// One Bresenham step: choose the diagonal or the straight move from the decision sign.
	always_comb begin
		if (decision_q > 0) begin
			dec_next = {decision_q[N+1], decision_q}
				+ $signed({2'b00, minor_delta_q, 1'b0})
				- $signed({2'b00, major_delta_q, 1'b0});
			minor_next = minor_step_neg_q ? minor_pos_q - N'(1) : minor_pos_q + N'(1);
		end else begin
			dec_next   = {decision_q[N+1], decision_q} + $signed({2'b00, minor_delta_q, 1'b0});
			minor_next = minor_pos_q;
		end
	end

	// Line state update on a load or on an advance that emits a point.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			major_pos_q      <= '0;
			minor_pos_q      <= '0;
			decision_q       <= '0;
			major_delta_q    <= '0;
			minor_delta_q    <= '0;
			remaining_q      <= '0;
			minor_step_neg_q <= 1'b0;
			steep_q          <= 1'b0;
			reversed_q       <= 1'b0;
		end else if (s1_fire && is_load) begin
			major_pos_q      <= su_major_pos;
			minor_pos_q      <= su_minor_pos;
			decision_q       <= su_decision;
			major_delta_q    <= su_major_delta;
			minor_delta_q    <= su_minor_delta;
			remaining_q      <= su_major_delta;
			minor_step_neg_q <= su_minor_step_neg;
			steep_q          <= su_steep;
			reversed_q       <= su_reversed;
		end else if (emit) begin
			major_pos_q <= major_pos_q + N'(1);
			minor_pos_q <= minor_next;
			decision_q  <= dec_next[N+1:0];
			remaining_q <= remaining_q - N'(1);
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_x_q    <= steep_q ? minor_pos_q : major_pos_q;
			out_y_q    <= steep_q ? major_pos_q : minor_pos_q;
			out_last_q <= (remaining_q == N'(1));
			out_back_q <= reversed_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DATA_W'({out_y_q, out_x_q});
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_back_q;

	// The countdown never exceeds the loaded major extent.
	assert property (@(posedge clk) disable iff (!arst_n) remaining_q <= major_delta_q)
		else $error("remaining count exceeds major extent");

	// The minor extent never exceeds the major extent.
	assert property (@(posedge clk) disable iff (!arst_n) minor_delta_q <= major_delta_q)
		else $error("minor extent exceeds major extent");

	// A point that is not taken stays in the result register.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |=> out_valid_q)
		else $error("result dropped while output stalled");

	// A final point leaves the line exhausted.
	assert property (@(posedge clk) disable iff (!arst_n)
		(emit && remaining_q == N'(1)) |=> (remaining_q == '0))
		else $error("line not exhausted after final point");

endmodule
